### hw/rtl/mnsts_pkg.sv
// ---------------------------------------------------------------------------
// MIDI note state package
// Types, field widths, message codes and register indexes shared by the
// note state controller, datapath and top level.
// ---------------------------------------------------------------------------
package mnsts_pkg;

    localparam int KEY_W   = 7;
    localparam int VEL_W   = 7;
    localparam int SLOT_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_DATA_W-1:0] SUSTAIN_CTRL_RST = 7'd64;
    localparam logic [CFG_DATA_W-1:0] PEDAL_THR_RST    = 7'd64;
    localparam logic [SLOT_W-1:0]     FIRST_SLOT       = 2'd1;

    typedef enum logic [1:0] {
        MODE_NOTE_ON     = 2'd0,
        MODE_NOTE_OFF    = 2'd1,
        MODE_CTRL_CHANGE = 2'd2,
        MODE_QUERY       = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SUSTAIN_CTRL = 1'b0,
        REG_PEDAL_THR    = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [VEL_W-1:0]  vel;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

### hw/rtl/mnsts_ctrl.sv
// ---------------------------------------------------------------------------
// MIDI note state controller
// Sequences one request at a time: capture with table read, execute the
// update, then present the result until the output side takes it.
// ---------------------------------------------------------------------------
module mnsts_ctrl
    import mnsts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_SEND = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_SEND);
    assign cmd.capture = (state_reg == ST_IDLE) && in_valid;
    assign cmd.execute = (state_reg == ST_EXEC);

    a_send_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> cmd.execute)
        else $error("captured request not executed next cycle");

    a_exec_then_send: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> (out_valid && !cmd.execute))
        else $error("executed request not presented");

endmodule

### hw/rtl/mnsts_dpath.sv
// ---------------------------------------------------------------------------
// MIDI note state datapath
// Key table memory with per-key live and sustained flags, pedal state,
// round-robin slot counter, configuration registers and result registers.
// ---------------------------------------------------------------------------
module mnsts_dpath
    import mnsts_pkg::*;
#(
    parameter int NUM_KEYS  = 128,
    parameter int NUM_SLOTS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    input  logic [1:0]            mode,
    input  logic [KEY_W-1:0]      key_or_controller,
    input  logic [VEL_W-1:0]      value,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic [KEY_W-1:0]      key,
    output logic [VEL_W-1:0]      key_velocity,
    output logic [SLOT_W-1:0]     key_slot,
    output logic                  key_sustained,
    output logic                  pedal_down,
    output logic [SLOT_W-1:0]     next_slot
);

    localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam logic [KEY_W:0]    KEY_LIMIT = (KEY_W+1)'(NUM_KEYS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS);

    // configuration
    logic [CFG_DATA_W-1:0] sus_ctrl_reg;
    logic [CFG_DATA_W-1:0] thr_reg;

    // control state
    logic                pedal_reg;
    logic                pedal_next;
    logic [SLOT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]   cnt_next;
    logic [NUM_KEYS-1:0] live_reg;
    logic [NUM_KEYS-1:0] live_next;
    logic [NUM_KEYS-1:0] sus_reg;
    logic [NUM_KEYS-1:0] sus_next;

    // captured request and table read
    mode_t            mode_reg;
    logic [KEY_W-1:0] key_in_reg;
    logic [VEL_W-1:0] val_reg;
    entry_t           rd_reg;
    entry_t           mem [NUM_KEYS];

    // result
    logic [KEY_W-1:0]  key_reg;
    logic [VEL_W-1:0]  vel_out_reg;
    logic [SLOT_W-1:0] slot_out_reg;
    logic              sus_out_reg;

    logic [ADDR_W-1:0] addr;
    logic              in_range;
    logic              is_pedal;
    logic              now_down;
    logic              note_on;
    logic              note_off;
    logic              mem_we;
    logic              hit;
    logic [VEL_W-1:0]  ent_vel;
    logic [SLOT_W-1:0] ent_slot;

    assign addr     = key_in_reg[ADDR_W-1:0];
    assign in_range = ({1'b0, key_in_reg} < KEY_LIMIT);
    assign is_pedal = (mode_reg == MODE_CTRL_CHANGE) && (key_in_reg == sus_ctrl_reg);
    assign now_down = (val_reg >= thr_reg);
    assign note_on  = in_range && (mode_reg == MODE_NOTE_ON) && (val_reg != '0);
    // a note-on at zero velocity counts as a note-off
    assign note_off = in_range && ((mode_reg == MODE_NOTE_OFF) ||
                      ((mode_reg == MODE_NOTE_ON) && (val_reg == '0)));

    always_comb
    begin
        pedal_next = pedal_reg;
        cnt_next   = cnt_reg;
        live_next  = live_reg;
        sus_next   = sus_reg;
        mem_we     = 1'b0;
        if (is_pedal)
        begin
            pedal_next = now_down;
            // pedal release: drop every key held only by the pedal
            if (pedal_reg && !now_down)
            begin
                live_next = live_reg & ~sus_reg;
                sus_next  = '0;
            end
        end
        if (note_on)
        begin
            sus_next[addr]  = 1'b0;
            live_next[addr] = 1'b1;
            mem_we          = 1'b1;
            cnt_next        = (cnt_reg == LAST_SLOT) ? FIRST_SLOT : cnt_reg + FIRST_SLOT;
        end
        if (note_off)
        begin
            if (pedal_reg)
            begin
                sus_next[addr] = 1'b1;
            end
            else
            begin
                live_next[addr] = 1'b0;
            end
        end
    end

    assign ent_vel  = note_on ? val_reg : rd_reg.vel;
    assign ent_slot = note_on ? cnt_reg : rd_reg.slot;
    assign hit      = in_range && live_next[addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sus_ctrl_reg <= SUSTAIN_CTRL_RST;
            thr_reg      <= PEDAL_THR_RST;
            pedal_reg    <= 1'b0;
            cnt_reg      <= FIRST_SLOT;
            live_reg     <= '0;
            sus_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_SUSTAIN_CTRL: sus_ctrl_reg <= cfg_data;
                    REG_PEDAL_THR:    thr_reg      <= cfg_data;
                endcase
            end
            if (cmd.execute)
            begin
                pedal_reg <= pedal_next;
                cnt_reg   <= cnt_next;
                live_reg  <= live_next;
                sus_reg   <= sus_next;
            end
        end
    end

    // table memory: read on capture, write on execute
    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
        begin
            mem[addr] <= '{vel: val_reg, slot: cnt_reg};
        end
        if (cmd.capture)
        begin
            rd_reg     <= mem[key_or_controller[ADDR_W-1:0]];
            mode_reg   <= mode_t'(mode);
            key_in_reg <= key_or_controller;
            val_reg    <= value;
        end
        if (cmd.execute)
        begin
            key_reg      <= key_in_reg;
            vel_out_reg  <= hit ? ent_vel : '0;
            slot_out_reg <= hit ? ent_slot : '0;
            sus_out_reg  <= in_range && sus_next[addr];
        end
    end

    assign key           = key_reg;
    assign key_velocity  = vel_out_reg;
    assign key_slot      = slot_out_reg;
    assign key_sustained = sus_out_reg;
    assign pedal_down    = pedal_reg;
    assign next_slot     = cnt_reg;

    a_no_sustain_pedal_up: assert property (@(posedge clk) disable iff (!rst_n)
        !pedal_reg |-> (sus_reg == '0))
        else $error("sustained key left with pedal up");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) && (cnt_reg <= LAST_SLOT))
        else $error("slot counter out of range");

    a_vel_slot_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |=> ((vel_out_reg != '0) == (slot_out_reg != '0)))
        else $error("velocity and slot disagree on key activity");

endmodule

### hw/rtl/midi_note_state_table_with_sustain.sv
// ---------------------------------------------------------------------------
// MIDI note state table with sustain
// Top level: per-key note table with round-robin slots and sustain pedal.
// ---------------------------------------------------------------------------
// Each request (note-on, note-off, controller change or query) returns one
// result: the addressed key's velocity, slot and sustained flag after the
// update, plus the pedal state and the next slot. The accepting edge captures
// the request together with the table memory's registered read; the update
// is then applied from those capture registers and loads the result registers,
// from which the result is presented. The next request is taken in the cycle
// after the result leaves, so requests never overlap: a new one waits until
// the last result has left, and output stall holds it off longer.
// A pedal release clears all sustained keys in the same update cycle through
// per-key flag registers. No clearing pass runs after reset.
// ---------------------------------------------------------------------------
module midi_note_state_table_with_sustain
    import mnsts_pkg::*;
#(
    parameter int NUM_KEYS  = 128,
    parameter int NUM_SLOTS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [KEY_W-1:0]      key_or_controller,
    input  logic [VEL_W-1:0]      value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_W-1:0]      key,
    output logic [VEL_W-1:0]      key_velocity,
    output logic [SLOT_W-1:0]     key_slot,
    output logic                  key_sustained,
    output logic                  pedal_down,
    output logic [SLOT_W-1:0]     next_slot,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;

    mnsts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mnsts_dpath #(
        .NUM_KEYS  (NUM_KEYS),
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .mode              (mode),
        .key_or_controller (key_or_controller),
        .value             (value),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .key               (key),
        .key_velocity      (key_velocity),
        .key_slot          (key_slot),
        .key_sustained     (key_sustained),
        .pedal_down        (pedal_down),
        .next_slot         (next_slot)
    );

endmodule

### test/note_table_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Note table checker
// Follows the key table, pedal state and slot counter from every accepted
// request, queues the entry the block should report and compares each
// accepted result against the oldest queued entry, field by field.
// ---------------------------------------------------------------------------
module note_table_checker
    import mnsts_pkg::*;
#(
    parameter int NUM_KEYS  = 128,
    parameter int NUM_SLOTS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            mode,
    input  logic [KEY_W-1:0]      key_or_controller,
    input  logic [VEL_W-1:0]      value,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [KEY_W-1:0]      key,
    input  logic [VEL_W-1:0]      key_velocity,
    input  logic [SLOT_W-1:0]     key_slot,
    input  logic                  key_sustained,
    input  logic                  pedal_down,
    input  logic [SLOT_W-1:0]     next_slot,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    waiting,
    output int                    results_seen,
    output int                    pedal_releases
);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [VEL_W-1:0]  velocity;
        logic [SLOT_W-1:0] slot;
        logic              sustained;
        logic              pedal;
        logic [SLOT_W-1:0] next_slot;
    } key_report_t;

    logic [VEL_W-1:0]      vel_tab  [NUM_KEYS];
    logic [SLOT_W-1:0]     slot_tab [NUM_KEYS];
    logic                  sus_tab  [NUM_KEYS];
    logic                  pedal;
    logic [SLOT_W-1:0]     slot_ctr;
    logic [CFG_DATA_W-1:0] sustain_cc;
    logic [CFG_DATA_W-1:0] pedal_thr;

    key_report_t reports_due[$];
    key_report_t due;

    task automatic report(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input int k, input string name, input int got, input int want);
        if (got != want)
            report($sformatf("key %0d %s: got %0d, expected %0d", k, name, got, want));
    endtask

    // Update the table for one request and queue the entry it reports.
    task automatic apply_request(input mode_t m, input logic [KEY_W-1:0] k,
                                 input logic [VEL_W-1:0] v);
        key_report_t e;
        logic        now_down;
        bit          in_range;
        in_range = (int'(k) < NUM_KEYS);
        if (m == MODE_CTRL_CHANGE) begin
            if (k == sustain_cc) begin
                now_down = (v >= pedal_thr);
                // pedal lifted: drop every key held only by the pedal
                if (pedal && !now_down) begin
                    pedal_releases++;
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        if (sus_tab[i]) begin
                            vel_tab[i]  = '0;
                            slot_tab[i] = '0;
                            sus_tab[i]  = 1'b0;
                        end
                    end
                end
                pedal = now_down;
            end
        end
        else if ((m == MODE_NOTE_ON || m == MODE_NOTE_OFF) && in_range) begin
            if (m == MODE_NOTE_ON && v != '0) begin
                sus_tab[k]  = 1'b0;
                vel_tab[k]  = v;
                slot_tab[k] = slot_ctr;
                slot_ctr    = (slot_ctr == SLOT_W'(NUM_SLOTS)) ? FIRST_SLOT : slot_ctr + 1'b1;
            end
            else if (pedal) begin
                sus_tab[k] = 1'b1;
            end
            else begin
                vel_tab[k]  = '0;
                slot_tab[k] = '0;
            end
        end
        e.key       = k;
        e.velocity  = in_range ? vel_tab[k]  : '0;
        e.slot      = in_range ? slot_tab[k] : '0;
        e.sustained = in_range ? sus_tab[k]  : 1'b0;
        e.pedal     = pedal;
        e.next_slot = slot_ctr;
        reports_due.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                vel_tab[i]  = '0;
                slot_tab[i] = '0;
                sus_tab[i]  = 1'b0;
            end
            pedal          = 1'b0;
            slot_ctr       = FIRST_SLOT;
            sustain_cc     = SUSTAIN_CTRL_RST;
            pedal_thr      = PEDAL_THR_RST;
            reports_due.delete();
            errors         = 0;
            waiting        = 0;
            results_seen   = 0;
            pedal_releases = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SUSTAIN_CTRL: sustain_cc = cfg_data;
                    REG_PEDAL_THR:    pedal_thr  = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (reports_due.size() == 0)
                begin
                    report($sformatf("result for key %0d with no request pending", key));
                end
                else
                begin
                    due = reports_due.pop_front();
                    check_field(due.key, "key", key, due.key);
                    check_field(due.key, "velocity", key_velocity, due.velocity);
                    check_field(due.key, "slot", key_slot, due.slot);
                    check_field(due.key, "sustained", key_sustained, due.sustained);
                    check_field(due.key, "pedal", pedal_down, due.pedal);
                    check_field(due.key, "next slot", next_slot, due.next_slot);
                end
            end
            if (in_valid && !in_stall)
                apply_request(mode_t'(mode), key_or_controller, value);
            waiting = reports_due.size();
        end
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MIDI note state table testbench
// Drives note, controller and query requests through a directed opening and
// random phases under several pedal settings, with random idle gaps on requests
// and stall bursts on results; the checker module predicts and compares.
// ---------------------------------------------------------------------------
module tb_top;
    import mnsts_pkg::*;

    localparam int N_PHASES     = 6;
    localparam int PHASE_ITEMS  = 75;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            mode = MODE_QUERY;
    logic [KEY_W-1:0]      key_or_controller = '0;
    logic [VEL_W-1:0]      value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [KEY_W-1:0]      key;
    logic [VEL_W-1:0]      key_velocity;
    logic [SLOT_W-1:0]     key_slot;
    logic                  key_sustained;
    logic                  pedal_down;
    logic [SLOT_W-1:0]     next_slot;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SUSTAIN_CTRL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors;
    int waiting;
    int results_seen;
    int pedal_releases;

    bit idle_on = 1'b1;
    int stall_left = 0;
    int requests_sent = 0;
    int settings_used = 0;
    int cur_sustain_cc = 64;
    int cur_threshold = 64;
    int phase_cc  [N_PHASES] = '{64, 0, 127, 0, 127, 64};
    int phase_thr [N_PHASES] = '{64, 127, 0, 0, 127, 1};

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    midi_note_state_table_with_sustain uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .key_or_controller (key_or_controller),
        .value             (value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .key               (key),
        .key_velocity      (key_velocity),
        .key_slot          (key_slot),
        .key_sustained     (key_sustained),
        .pedal_down        (pedal_down),
        .next_slot         (next_slot),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    note_table_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .key_or_controller (key_or_controller),
        .value             (value),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .key               (key),
        .key_velocity      (key_velocity),
        .key_slot          (key_slot),
        .key_sustained     (key_sustained),
        .pedal_down        (pedal_down),
        .next_slot         (next_slot),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .errors            (errors),
        .waiting           (waiting),
        .results_seen      (results_seen),
        .pedal_releases    (pedal_releases)
    );

    // Result-side stall in random bursts, started only while idle_on is set.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_req(input mode_t m, input int k, input int v);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        mode              <= m;
        key_or_controller <= k[KEY_W-1:0];
        value             <= v[VEL_W-1:0];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
    endtask

    // Hold off until every queued result has come back, then let the block settle.
    task automatic drain_requests();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input int data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == REG_SUSTAIN_CTRL)
            cur_sustain_cc = data;
        else
            cur_threshold = data;
    endtask

    task automatic send_random(input int base);
        int pick;
        int k;
        int v;
        pick = $urandom_range(0, 99);
        k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                        : (base + $urandom_range(0, 7)) % 128;
        v = $urandom_range(0, 127);
        if (pick < 35)
        begin
            if ($urandom_range(0, 9) == 0)
                v = 0;
            send_req(MODE_NOTE_ON, k, v);
        end
        else if (pick < 62)
        begin
            send_req(MODE_NOTE_OFF, k, v);
        end
        else if (pick < 80)
        begin
            // favor values right at the threshold edge
            case ($urandom_range(0, 4))
                0: v = 0;
                1: v = 127;
                2: v = cur_threshold;
                3: v = (cur_threshold == 0) ? 0 : cur_threshold - 1;
                default: ;
            endcase
            send_req(MODE_CTRL_CHANGE, cur_sustain_cc, v);
        end
        else if (pick < 90)
        begin
            send_req(MODE_CTRL_CHANGE, $urandom_range(0, 127), v);
        end
        else
        begin
            send_req(MODE_QUERY, k, v);
        end
    endtask

    task automatic run_directed();
        send_req(MODE_QUERY, 0, 0);
        send_req(MODE_NOTE_ON, 0, 127);
        send_req(MODE_NOTE_ON, 127, 1);
        send_req(MODE_NOTE_ON, 60, 100);
        send_req(MODE_NOTE_ON, 61, 50);         // slot wraps back to the first
        send_req(MODE_NOTE_ON, 60, 0);          // zero velocity acts as note-off
        send_req(MODE_CTRL_CHANGE, 64, 64);     // exactly at threshold: down
        send_req(MODE_NOTE_OFF, 0, 33);
        send_req(MODE_NOTE_OFF, 5, 0);          // idle key still gets marked
        send_req(MODE_NOTE_ON, 127, 0);
        send_req(MODE_CTRL_CHANGE, 64, 127);    // down again, no edge
        send_req(MODE_CTRL_CHANGE, 0, 127);     // other controller reports key 0
        send_req(MODE_NOTE_ON, 0, 90);          // retrigger clears sustained
        send_req(MODE_QUERY, 127, 127);
        send_req(MODE_CTRL_CHANGE, 64, 63);     // release clears sustained keys
        send_req(MODE_QUERY, 5, 85);
        send_req(MODE_CTRL_CHANGE, 64, 0);      // up again, no edge
        send_req(MODE_NOTE_OFF, 61, 127);
        send_req(MODE_QUERY, 0, 42);
        send_req(MODE_QUERY, 127, 0);
    endtask

    initial
    begin
        int base;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_requests();
            if (p == 3)
            begin
                phase_cc[p]  = $urandom_range(0, 127);
                phase_thr[p] = $urandom_range(0, 127);
            end
            cfg_write(REG_SUSTAIN_CTRL, phase_cc[p]);
            cfg_write(REG_PEDAL_THR, phase_thr[p]);
            settings_used++;
            idle_on = (p != N_PHASES - 1) && ($urandom_range(0, 4) != 0 || p == 0);
            base = $urandom_range(0, 127);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    base = $urandom_range(0, 127);
                send_random(base);
            end
        end
        drain_requests();
        repeat (10) @(posedge clk);
        $display("Sent %0d requests over %0d pedal settings; checked %0d results.",
                 requests_sent, settings_used, results_seen);
        $display("Pedal lifts seen: %0d.", pedal_releases);
        if (waiting != 0)
            $display("%0d results never arrived", waiting);
        if (errors == 0 && waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout: run did not finish");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
